// File: src/shortest_remaining_time_scheduler_defines.svh
// Assertion macros shared by the scheduler.
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_DEFINES_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_DEFINES_SVH

// Checked only out of reset.
`define SRTF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SRTF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/srtf_pkg.sv
package srtf_pkg;

    localparam int SLOTS     = 4;
    localparam int TIME_BITS = 16;
    localparam int SLOT_W    = $clog2(SLOTS);

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [SLOT_W-1:0]    t_idx;

    localparam t_time TIME_MAX = '1;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [7:0] id;
        t_time      arr;
        t_time      burst;
    } t_slot_info;

    typedef struct packed {
        t_slot_info info;
        t_time      left;
    } t_slot;

    typedef struct packed {
        logic  en;
        logic  clr;
        t_idx  idx;
        t_slot data;
    } t_slot_wr;

    typedef struct packed {
        logic        ran;
        logic [7:0]  ran_id;
        logic        switched;
        logic        finished;
        logic [15:0] turnaround;
        logic [15:0] waiting;
        logic [15:0] now_time;
    } t_res;

    function automatic t_time sat_inc(input t_time v);
        return (v == TIME_MAX) ? v : v + TIME_BITS'(1);
    endfunction

endpackage

// File: src/shortest_remaining_time_scheduler.sv
// Channel   Dir  Handshake         Payload
// s_axis    in   tvalid / tready   tuser: mode; tdata: slot, proc_id, arrive_at, burst_len
// m_axis    out  tvalid / tready   tdata: ran, ran_id, switched, finished, turnaround,
//                                  waiting, now_time
//
// One word at a time. For a tick word one compare unit walks the slots, one per cycle,
// then the EXEC step updates state and the FIN step hands the result over. Load and
// clear skip the walk.
// Reset is synchronous, active low; all slots read as empty afterwards.
// A result waits in the output register; a stalled output holds the block in its
// final step until the register frees up.
`include "shortest_remaining_time_scheduler_defines.svh"

module shortest_remaining_time_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] mode
    input  logic [47:0] i_s_axis_tdata,  // slot, proc_id, arrive_at, burst_len, zero pad
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata   // ran, ran_id, switched, finished, turnaround,
                                         // waiting, now_time, zero pad
);
    import srtf_pkg::*;

    t_idx     rd_idx;
    t_slot    rd;
    t_slot_wr wr;
    logic     res_valid, res_ready;
    t_res     res;

    t_res     r_out;
    logic     r_out_valid;

    logic     in_acc, out_idle;

    srtf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_mode      (i_s_axis_tuser),
        .i_slot      (i_s_axis_tdata[1:0]),
        .i_proc_id   (i_s_axis_tdata[9:2]),
        .i_arrive_at (i_s_axis_tdata[25:10]),
        .i_burst_len (i_s_axis_tdata[41:26]),
        .o_rd_idx    (rd_idx),
        .i_rd        (rd),
        .o_wr        (wr),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    srtf_slots u_slots (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (rd_idx),
        .o_rd     (rd),
        .i_wr     (wr)
    );

    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.now_time, r_out.waiting, r_out.turnaround,
                              r_out.finished, r_out.switched, r_out.ran_id, r_out.ran};

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_idle = o_m_axis_tvalid && !r_out.ran;

    `SRTF_ASSERT(a_busy_after_accept, in_acc |=> !o_s_axis_tready, "ready after accepting")
    `SRTF_ASSERT(a_idle_clean, out_idle |-> !(r_out.finished || r_out.switched), "idle flags")
    `SRTF_ASSERT(a_wait, o_m_axis_tvalid |-> r_out.waiting <= r_out.turnaround, "bad waiting")
    `SRTF_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule

// File: src/srtf_slots.sv
module srtf_slots (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srtf_pkg::t_idx     i_rd_idx,
    output srtf_pkg::t_slot    o_rd,
    input  srtf_pkg::t_slot_wr i_wr
);
    import srtf_pkg::*;

    t_slot_info r_info [SLOTS];
    t_time      r_left [SLOTS];

    // remaining time: zero means empty, so only this part is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.clr) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_left[k] <= '0;
            end
        end else if (i_wr.en) begin
            r_left[i_wr.idx] <= i_wr.data.left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && !i_wr.clr) begin
            r_info[i_wr.idx] <= i_wr.data.info;
        end
    end

    assign o_rd.info = r_info[i_rd_idx];
    assign o_rd.left = r_left[i_rd_idx];

endmodule

// File: src/srtf_ctrl.sv
module srtf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_mode,
    input  logic [1:0]         i_slot,
    input  logic [7:0]         i_proc_id,
    input  logic [15:0]        i_arrive_at,
    input  logic [15:0]        i_burst_len,
    output srtf_pkg::t_idx     o_rd_idx,
    input  srtf_pkg::t_slot    i_rd,
    output srtf_pkg::t_slot_wr o_wr,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output srtf_pkg::t_res     o_res
);
    import srtf_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_mode;
    logic [1:0] r_slot;
    logic [7:0] r_pid;
    t_time      r_arr, r_bur;
    t_time      r_time;
    logic       r_prev_ran;
    logic [7:0] r_prev_id;
    t_idx       r_idx;
    logic       r_best_vld;
    t_idx       r_best_idx;
    t_slot      r_best;
    t_res       r_res;
    t_res       n_res;

    logic  accept, last, elig, better, slot_ok, done;
    t_time left_dec, tat, wt;

    assign accept   = (r_state == ST_IDLE) && i_in_valid;
    assign last     = (r_idx == SLOT_W'(SLOTS - 1));
    assign slot_ok  = (32'(r_slot) < 32'(SLOTS));
    assign left_dec = r_best.left - TIME_BITS'(1);
    assign done     = (left_dec == '0);

    // shared compare unit: one slot against the best so far
    assign elig   = (i_rd.left != '0) && (i_rd.info.arr <= r_time);
    assign better = !r_best_vld || (i_rd.left < r_best.left) ||
                    ((i_rd.left == r_best.left) && (i_rd.info.arr < r_best.info.arr));

    assign tat = sat_inc(r_time) - r_best.info.arr;
    assign wt  = (tat >= r_best.info.burst) ? tat - r_best.info.burst : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_mode == MODE_TICK) ? ST_SCAN : ST_EXEC;
                end
            end
            ST_SCAN: begin
                if (last) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: n_state = ST_FIN;
            ST_FIN: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_rd_idx    = r_idx;
        o_wr        = '0;
        o_res       = r_res;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_SCAN: ;
            ST_EXEC: begin
                case (r_mode)
                    MODE_LOAD: begin
                        o_wr.en              = slot_ok;
                        o_wr.idx             = SLOT_W'(r_slot);
                        o_wr.data.info.id    = r_pid;
                        o_wr.data.info.arr   = r_arr;
                        o_wr.data.info.burst = r_bur;
                        o_wr.data.left       = r_bur;
                    end
                    MODE_TICK: begin
                        o_wr.en        = r_best_vld;
                        o_wr.idx       = r_best_idx;
                        o_wr.data.info = r_best.info;
                        o_wr.data.left = left_dec;
                    end
                    MODE_CLEAR: o_wr.clr = 1'b1;
                    default: ;
                endcase
            end
            ST_FIN: o_res_valid = 1'b1;
            default: ;
        endcase
    end

    // result word built from the chosen slot
    always_comb begin
        n_res          = '0;
        n_res.now_time = 16'(r_time);
        if ((r_mode == MODE_TICK) && r_best_vld) begin
            n_res.ran      = 1'b1;
            n_res.ran_id   = r_best.info.id;
            n_res.switched = r_prev_ran && (r_prev_id != r_best.info.id);
            if (done) begin
                n_res.finished   = 1'b1;
                n_res.turnaround = 16'(tat);
                n_res.waiting    = 16'(wt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_time     <= '0;
            r_prev_ran <= 1'b0;
            r_prev_id  <= '0;
            r_best_vld <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_mode     <= i_mode;
                        r_slot     <= i_slot;
                        r_pid      <= i_proc_id;
                        r_arr      <= TIME_BITS'(i_arrive_at);
                        r_bur      <= TIME_BITS'(i_burst_len);
                        r_idx      <= '0;
                        r_best_vld <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (elig && better) begin
                        r_best_vld <= 1'b1;
                        r_best     <= i_rd;
                        r_best_idx <= r_idx;
                    end
                    r_idx <= r_idx + SLOT_W'(1);
                end
                ST_EXEC: begin
                    r_res <= n_res;
                    case (r_mode)
                        MODE_TICK: begin
                            if (r_best_vld) begin
                                r_prev_ran <= 1'b1;
                                r_prev_id  <= r_best.info.id;
                            end else begin
                                r_prev_ran <= 1'b0;
                            end
                            r_time <= sat_inc(r_time);
                        end
                        MODE_CLEAR: begin
                            r_time     <= '0;
                            r_prev_ran <= 1'b0;
                            r_prev_id  <= '0;
                        end
                        default: ;
                    endcase
                end
                ST_FIN: ;
                default: ;
            endcase
        end
    end

endmodule
